/* rtl/date_difference_days_core_defines.svh */
// Assertion macros shared by the date difference core.
`ifndef DATE_DIFFERENCE_DAYS_CORE_DEFINES_SVH
`define DATE_DIFFERENCE_DAYS_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DDD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date difference core: check failed");

// Next-cycle implication, checked out of reset.
`define DDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date difference core: check failed");

`endif

/* rtl/ddd_pkg.sv */
// Types, constants and the month table of the date difference core.
package ddd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DIFF_W  = 23;
    localparam int unsigned DNUM_W  = 23;

    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x < 4121
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 17;

    localparam logic [DIFF_W-1:0] DIFF_MAX = 23'h3FFFFF;
    localparam logic [DIFF_W-1:0] DIFF_MIN = 23'h400000;

    typedef enum logic [1:0] {
        ORDER_BEFORE = 2'd0,
        ORDER_EQUAL  = 2'd1,
        ORDER_AFTER  = 2'd2
    } order_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day_a;
        logic [MONTH_W-1:0] month_a;
        logic [YEAR_W-1:0]  year_a;
        logic [DAY_W-1:0]   day_b;
        logic [MONTH_W-1:0] month_b;
        logic [YEAR_W-1:0]  year_b;
        logic               include_last_day;
    } ddd_in_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        order_t                   order;
    } ddd_out_t;

    typedef struct packed {
        logic   valid;
        order_t order;
        logic   inc;
    } ddd_ctl_t;

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        unique case (m)
            4'd0, 4'd1: n = 9'd0;
            4'd2:       n = 9'd31;
            4'd3:       n = 9'd59;
            4'd4:       n = 9'd90;
            4'd5:       n = 9'd120;
            4'd6:       n = 9'd151;
            4'd7:       n = 9'd181;
            4'd8:       n = 9'd212;
            4'd9:       n = 9'd243;
            4'd10:      n = 9'd273;
            4'd11:      n = 9'd304;
            4'd12:      n = 9'd334;
            default:    n = 9'd365;
        endcase
        return n;
    endfunction

endpackage

/* rtl/date_difference_days_core.sv */
// Top level of the date difference core.
// Takes a date pair on every clock where start is high and gives its result
// marked by a one-cycle result_strobe. One pair per clock is sustained; busy
// stays low. The result passes four register stages: the reciprocal multiply
// for the century quotient, the leap count, the day number sum, and the signed
// difference with saturation.
`include "date_difference_days_core_defines.svh"

module date_difference_days_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ddd_pkg::ddd_in_t  operands,
    output ddd_pkg::ddd_out_t result,
    output logic              result_strobe
);
    import ddd_pkg::*;

    logic              accept;
    logic              s1_valid;
    ddd_ctl_t          ctl;
    logic [DNUM_W-1:0] dnum_a;
    logic [DNUM_W-1:0] dnum_b;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ddd_order u_order (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .operands (operands),
        .s1_valid (s1_valid),
        .ctl      (ctl)
    );

    ddd_daynum u_daynum_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .day      (operands.day_a),
        .month    (operands.month_a),
        .year     (operands.year_a),
        .day_num  (dnum_a)
    );

    ddd_daynum u_daynum_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .day      (operands.day_b),
        .month    (operands.month_b),
        .year     (operands.year_b),
        .day_num  (dnum_b)
    );

    ddd_finish u_finish (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .dnum_a        (dnum_a),
        .dnum_b        (dnum_b),
        .result        (result),
        .result_strobe (result_strobe)
    );

    `DDD_ASSERT_IMP(a_latency, result_strobe, $past(start, 4))

endmodule

/* rtl/ddd_daynum.sv */
// Three-stage absolute day number of one date (proleptic Gregorian).
`include "date_difference_days_core_defines.svh"

module ddd_daynum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s1_valid,
    input  logic [ddd_pkg::DAY_W-1:0]   day,
    input  logic [ddd_pkg::MONTH_W-1:0] month,
    input  logic [ddd_pkg::YEAR_W-1:0]  year,
    output logic [ddd_pkg::DNUM_W-1:0]  day_num
);
    import ddd_pkg::*;

    // stage 1
    logic [DAY_W-1:0]   day_s1_reg,   day_s1_next;
    logic [MONTH_W-1:0] month_s1_reg, month_s1_next;
    logic [YEAR_W-1:0]  year_s1_reg,  year_s1_next;
    logic [24:0]        prod_s1_reg,  prod_s1_next;

    // stage 2
    logic [DAY_W-1:0]   day_s2_reg,   day_s2_next;
    logic [MONTH_W-1:0] month_s2_reg, month_s2_next;
    logic [DNUM_W-1:0]  ybase_s2_reg, ybase_s2_next;
    logic [12:0]        leaps_s2_reg, leaps_s2_next;
    logic               leap_s2_reg,  leap_s2_next;

    // stage 3
    logic [DNUM_W-1:0]  dnum_s3_reg,  dnum_s3_next;

    logic [7:0]  q100;
    logic [14:0] mult100;
    logic        rem100_zero;
    logic        div400;
    logic [12:0] ceil4;
    logic [8:0]  ceil100;
    logic [6:0]  ceil400;

    always_comb
    begin
        day_s1_next   = day;
        month_s1_next = month;
        year_s1_next  = year;
        prod_s1_next  = 25'(year[YEAR_W-1:2]) * 25'(RECIP_25);
    end

    always_comb
    begin
        q100        = prod_s1_reg[RECIP_SHIFT+7:RECIP_SHIFT];
        mult100     = 15'(q100) * 15'd100;
        rem100_zero = ({1'b0, year_s1_reg} == mult100);
        div400      = rem100_zero && (q100[1:0] == 2'd0);
        ceil4       = 13'(year_s1_reg[YEAR_W-1:2]) + 13'(year_s1_reg[1:0] != 2'd0);
        ceil100     = 9'(q100) + 9'(!rem100_zero);
        ceil400     = 7'(q100[7:2]) + 7'(!div400);

        day_s2_next   = day_s1_reg;
        month_s2_next = month_s1_reg;
        ybase_s2_next = DNUM_W'(year_s1_reg) * DNUM_W'(365);
        leaps_s2_next = ceil4 - 13'(ceil100) + 13'(ceil400);
        leap_s2_next  = (year_s1_reg[1:0] == 2'd0) && (!rem100_zero || div400);
    end

    always_comb
    begin
        dnum_s3_next = ybase_s2_reg + DNUM_W'(leaps_s2_reg)
                     + DNUM_W'(days_before_month(month_s2_reg)) + DNUM_W'(day_s2_reg)
                     + DNUM_W'(leap_s2_reg && (month_s2_reg > 4'd2));
    end

    always_ff @(posedge clk)
    begin
        day_s1_reg   <= day_s1_next;
        month_s1_reg <= month_s1_next;
        year_s1_reg  <= year_s1_next;
        prod_s1_reg  <= prod_s1_next;
        day_s2_reg   <= day_s2_next;
        month_s2_reg <= month_s2_next;
        ybase_s2_reg <= ybase_s2_next;
        leaps_s2_reg <= leaps_s2_next;
        leap_s2_reg  <= leap_s2_next;
        dnum_s3_reg  <= dnum_s3_next;
    end

    assign day_num = dnum_s3_reg;

    // reciprocal quotient must bracket the year
    `DDD_ASSERT_IMP(a_q100_exact, s1_valid,
        (mult100 <= {1'b0, year_s1_reg}) && ({1'b0, year_s1_reg} < mult100 + 15'd100))

endmodule

/* rtl/ddd_order.sv */
// Date order compare and control pipeline aligned to the day number stages.
module ddd_order (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ddd_pkg::ddd_in_t operands,
    output logic             s1_valid,
    output ddd_pkg::ddd_ctl_t ctl
);
    import ddd_pkg::*;

    ddd_ctl_t s1_reg, s1_next;
    ddd_ctl_t s2_reg;
    ddd_ctl_t s3_reg;

    logic [DAY_W+MONTH_W+YEAR_W-1:0] key_a;
    logic [DAY_W+MONTH_W+YEAR_W-1:0] key_b;

    always_comb
    begin
        key_a = {operands.year_a, operands.month_a, operands.day_a};
        key_b = {operands.year_b, operands.month_b, operands.day_b};
        s1_next.valid = accept;
        s1_next.inc   = operands.include_last_day;
        priority if (key_a < key_b)
            s1_next.order = ORDER_BEFORE;
        else if (key_a == key_b)
            s1_next.order = ORDER_EQUAL;
        else
            s1_next.order = ORDER_AFTER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    assign s1_valid = s1_reg.valid;
    assign ctl      = s3_reg;

endmodule

/* rtl/ddd_finish.sv */
// Signed difference, last-day adjust, saturation and result register.
`include "date_difference_days_core_defines.svh"

module ddd_finish (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ddd_pkg::ddd_ctl_t          ctl,
    input  logic [ddd_pkg::DNUM_W-1:0] dnum_a,
    input  logic [ddd_pkg::DNUM_W-1:0] dnum_b,
    output ddd_pkg::ddd_out_t          result,
    output logic                       result_strobe
);
    import ddd_pkg::*;

    ddd_out_t result_reg, result_next;
    logic     strobe_reg, strobe_next;

    logic signed [DNUM_W+1:0] diff;
    logic signed [DNUM_W+1:0] adj;

    always_comb
    begin
        diff = $signed({2'b00, dnum_b}) - $signed({2'b00, dnum_a});
        if (ctl.order == ORDER_AFTER)
            adj = diff - $signed((DNUM_W+2)'(ctl.inc));
        else
            adj = diff + $signed((DNUM_W+2)'(ctl.inc));

        result_next.order = ctl.order;
        if (adj[DNUM_W+1:DIFF_W-1] == '0 || adj[DNUM_W+1:DIFF_W-1] == '1)
            result_next.day_difference = adj[DIFF_W-1:0];
        else if (adj[DNUM_W+1])
            result_next.day_difference = DIFF_MIN;
        else
            result_next.day_difference = DIFF_MAX;

        strobe_next = ctl.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= strobe_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    `DDD_ASSERT_IMP(a_equal_count, strobe_reg && result_reg.order == ORDER_EQUAL,
        result_reg.day_difference == 23'sd0 || result_reg.day_difference == 23'sd1)
    `DDD_ASSERT_NEXT(a_strobe_follows, ctl.valid, strobe_reg)

endmodule
